FILE: hw/rtl/lpd_pkg.sv
// ----------------------------------------------------------------------------
// Length-prefixed deframer package
// Shared widths, codes and the result record of the deframer.
// ----------------------------------------------------------------------------
package lpd_pkg;

    // Width of the running stream offset counter (16 to 64).
    localparam int OFFSET_BITS = 32;

    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 24;
    localparam int START_W     = 32;
    localparam int CFG_DATA_W  = 8;
    localparam int CFG_INDEX_W = 1;

    typedef logic [OFFSET_BITS-1:0] t_offset;
    typedef logic [LEN_W-1:0]       t_length;
    typedef logic [BYTE_W-1:0]      t_byte;

    typedef enum logic [1:0] {
        ST_PAYLOAD = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_BAD_CMD = 2'd2
    } t_status;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DIRECTION   = 1'd0,
        CFG_MAX_COMMAND = 1'd1
    } t_cfg_index;

    localparam logic  DIR_REQUEST     = 1'b0;
    localparam t_byte MAX_COMMAND_RST = 8'd31;

    typedef struct packed {
        t_status            status;
        t_byte              payload_byte;
        logic               first_of_packet;
        logic               last_of_packet;
        t_byte              sequence_number;
        logic [START_W-1:0] packet_start_offset;
    } t_result;

endpackage

FILE: hw/rtl/lpd_in_if.sv
// ----------------------------------------------------------------------------
// Deframer input channel
// One raw stream byte per request, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lpd_in_if;
    logic          valid;
    logic          ready;
    lpd_pkg::t_byte data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

FILE: hw/rtl/lpd_out_if.sv
// ----------------------------------------------------------------------------
// Deframer output channel
// One deframed result per request, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lpd_out_if;
    logic                               valid;
    logic                               ready;
    logic [1:0]                         status;
    logic [lpd_pkg::BYTE_W-1:0]         payload_byte;
    logic                               first_of_packet;
    logic                               last_of_packet;
    logic [lpd_pkg::BYTE_W-1:0]         sequence_number;
    logic [lpd_pkg::START_W-1:0]        packet_start_offset;

    modport source (output valid, output status, output payload_byte,
                    output first_of_packet, output last_of_packet,
                    output sequence_number, output packet_start_offset,
                    input ready);
    modport sink   (input valid, input status, input payload_byte,
                    input first_of_packet, input last_of_packet,
                    input sequence_number, input packet_start_offset,
                    output ready);
endinterface

FILE: hw/rtl/length_prefixed_packet_deframer.sv
// ----------------------------------------------------------------------------
// Length-prefixed packet deframer
// Each result is registered in the output register, or in the skid stage
// while the output stalls. Throughput: one byte per cycle while ready is high.
// Input ready drops only while the skid stage holds a stalled result.
// Reset (synchronous, active low) clears parser state and the buffer, and
// loads the registers with request direction and a command limit of 31.
// ----------------------------------------------------------------------------
module length_prefixed_packet_deframer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [lpd_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [lpd_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    lpd_in_if.sink                              i_in,
    lpd_out_if.source                           o_out
);

    // A request is taken from the input whenever the output buffer has room.
    // Header bytes update only the parser state; payload bytes, empty packet
    // markers and the single bad command error each produce one result.
    logic             take;
    logic             buf_ready;
    logic             res_valid;
    lpd_pkg::t_result res;
    lpd_pkg::t_result out_res;

    assign i_in.ready = buf_ready;
    assign take       = i_in.valid && buf_ready;

    lpd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_take      (take),
        .i_byte      (i_in.data_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // The output register plus a skid stage keep input flowing while the
    // consumer stalls, until the skid stage holds a result.
    lpd_outbuf u_outbuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (res_valid),
        .i_res       (res),
        .o_ready     (buf_ready),
        .o_valid     (o_out.valid),
        .i_pop_ready (o_out.ready),
        .o_res       (out_res)
    );

    assign o_out.status              = out_res.status;
    assign o_out.payload_byte        = out_res.payload_byte;
    assign o_out.first_of_packet     = out_res.first_of_packet;
    assign o_out.last_of_packet      = out_res.last_of_packet;
    assign o_out.sequence_number     = out_res.sequence_number;
    assign o_out.packet_start_offset = out_res.packet_start_offset;

endmodule

FILE: hw/rtl/lpd_core.sv
// ----------------------------------------------------------------------------
// Deframer core
// Header/payload tracking, offset counting, command check and config.
// ----------------------------------------------------------------------------
module lpd_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [lpd_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [lpd_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_take,
    input  lpd_pkg::t_byte                      i_byte,
    output logic                                o_res_valid,
    output lpd_pkg::t_result                    o_res
);

    typedef enum logic [4:0] {
        PH_HDR0    = 5'b00001,
        PH_HDR1    = 5'b00010,
        PH_HDR2    = 5'b00100,
        PH_HDR3    = 5'b01000,
        PH_PAYLOAD = 5'b10000
    } t_phase;

    t_phase            r_phase,         n_phase;
    lpd_pkg::t_length  r_payload_length, n_payload_length;
    lpd_pkg::t_length  r_bytes_left,    n_bytes_left;
    lpd_pkg::t_byte    r_held_seq,      n_held_seq;
    lpd_pkg::t_offset  r_stream_offset, n_stream_offset;
    lpd_pkg::t_offset  r_current_start, n_current_start;
    logic              r_halted,        n_halted;
    logic              r_direction;
    lpd_pkg::t_byte    r_max_command;

    logic              first_byte;
    lpd_pkg::t_length  left_dec;

    assign first_byte = (r_bytes_left == r_payload_length);
    assign left_dec   = r_bytes_left - lpd_pkg::t_length'(1);

    always_comb begin
        n_phase          = r_phase;
        n_payload_length = r_payload_length;
        n_bytes_left     = r_bytes_left;
        n_held_seq       = r_held_seq;
        n_stream_offset  = r_stream_offset;
        n_current_start  = r_current_start;
        n_halted         = r_halted;
        o_res_valid      = 1'b0;
        o_res.status              = lpd_pkg::ST_PAYLOAD;
        o_res.payload_byte        = '0;
        o_res.first_of_packet     = 1'b0;
        o_res.last_of_packet      = 1'b0;
        o_res.sequence_number     = r_held_seq;
        o_res.packet_start_offset = lpd_pkg::START_W'(r_current_start);

        if (i_take && !r_halted) begin
            n_stream_offset = r_stream_offset + lpd_pkg::t_offset'(1);
            case (r_phase)
                PH_HDR1: begin
                    n_payload_length[15:8] = i_byte;
                    n_phase = PH_HDR2;
                end
                PH_HDR2: begin
                    n_payload_length[23:16] = i_byte;
                    n_phase = PH_HDR3;
                end
                PH_HDR3: begin
                    n_held_seq = i_byte;
                    if (r_payload_length == '0) begin
                        // Empty packet: a single marker, no command check.
                        n_phase = PH_HDR0;
                        o_res_valid           = 1'b1;
                        o_res.status          = lpd_pkg::ST_EMPTY;
                        o_res.first_of_packet = 1'b1;
                        o_res.last_of_packet  = 1'b1;
                        o_res.sequence_number = i_byte;
                    end else begin
                        n_bytes_left = r_payload_length;
                        n_phase      = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    o_res_valid = 1'b1;
                    if (first_byte && r_direction == lpd_pkg::DIR_REQUEST &&
                        i_byte > r_max_command) begin
                        n_halted              = 1'b1;
                        o_res.status          = lpd_pkg::ST_BAD_CMD;
                        o_res.first_of_packet = 1'b1;
                    end else begin
                        n_bytes_left          = left_dec;
                        o_res.payload_byte    = i_byte;
                        o_res.first_of_packet = first_byte;
                        o_res.last_of_packet  = (left_dec == '0);
                        if (left_dec == '0) begin
                            n_phase = PH_HDR0;
                        end
                    end
                end
                default: begin
                    // First header byte; also covers any stray phase code.
                    n_current_start  = r_stream_offset;
                    n_payload_length = lpd_pkg::t_length'(i_byte);
                    n_phase          = PH_HDR1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_HDR0;
            r_payload_length <= '0;
            r_bytes_left     <= '0;
            r_held_seq       <= '0;
            r_stream_offset  <= '0;
            r_current_start  <= '0;
            r_halted         <= 1'b0;
            r_direction      <= lpd_pkg::DIR_REQUEST;
            r_max_command    <= lpd_pkg::MAX_COMMAND_RST;
        end else begin
            r_phase          <= n_phase;
            r_payload_length <= n_payload_length;
            r_bytes_left     <= n_bytes_left;
            r_held_seq       <= n_held_seq;
            r_stream_offset  <= n_stream_offset;
            r_current_start  <= n_current_start;
            r_halted         <= n_halted;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    lpd_pkg::CFG_DIRECTION:   r_direction   <= i_cfg_data[0];
                    lpd_pkg::CFG_MAX_COMMAND: r_max_command <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Once halted, no byte may produce a result.
    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |-> !o_res_valid) else $error("result after halt");

    // A bad command result always leaves the block halted.
    a_err_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.status == lpd_pkg::ST_BAD_CMD) |=> r_halted)
        else $error("bad command did not halt");

    // The last payload byte returns the parser to the first header byte.
    a_last_rewinds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.status == lpd_pkg::ST_PAYLOAD && o_res.last_of_packet)
        |=> (r_phase == PH_HDR0)) else $error("last byte did not end packet");

    // Offset advances by exactly one for each byte taken while running.
    a_offset_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && !r_halted) |=>
        (r_stream_offset == $past(r_stream_offset) + lpd_pkg::t_offset'(1)))
        else $error("stream offset step wrong");

endmodule

FILE: hw/rtl/lpd_outbuf.sv
// ----------------------------------------------------------------------------
// Deframer output buffer
// Result register with a skid stage so the input keeps flowing.
// ----------------------------------------------------------------------------
module lpd_outbuf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  lpd_pkg::t_result   i_res,
    output logic               o_ready,
    output logic               o_valid,
    input  logic               i_pop_ready,
    output lpd_pkg::t_result   o_res
);

    logic             r_out_valid;
    logic             r_skid_valid;
    lpd_pkg::t_result r_out;
    lpd_pkg::t_result r_skid;
    logic             pop;

    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_res   = r_out;
    assign pop     = r_out_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || pop) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || pop) begin
            r_out <= r_skid_valid ? r_skid : i_res;
        end else if (i_push) begin
            r_skid <= i_res;
        end
    end

    // The skid stage only fills behind an occupied output register.
    a_skid_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid) else $error("skid without output");

    // A push into a full buffer would drop a result.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && i_push) |-> 1'b0) else $error("push into full buffer");

    // A stalled output with a pending push must park it in the skid stage.
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_pop_ready && i_push) |=> r_skid_valid)
        else $error("pushed result lost");

endmodule
